@@ rtl/core/kncs_pkg.sv @@
// package for the k-nearest candidate selector
// holds defaults, widths, function codes, controller state type and control/status structs; no dependencies
`default_nettype none
package kncs_pkg;
  localparam int MAX_K_DEF      = 32;
  localparam int COORD_BITS_DEF = 24;
  localparam int ID_BITS_DEF    = 20;
  localparam int DIST_BITS      = 50;
  localparam int OUT_ID_BITS    = 20;
  localparam int KEEP_BITS      = 6;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_CAND  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIST, ST_SUM, ST_DECIDE, ST_SCAN, ST_SCANW, ST_REPL,
    ST_MSCAN, ST_MSCANW, ST_EMIT, ST_EMITW, ST_EMPTY
  } state_t;

  typedef struct packed {
    logic load_query;
    logic load_cand;
    logic calc_dist;
    logic calc_sum;
    logic append;
    logic scan_init;
    logic scan_read;
    logic scan_step;
    logic replace;
    logic emit_init;
    logic emit_read;
    logic emit_out;
    logic emit_empty;
  } ctrl_t;

  typedef struct packed {
    logic is_start;
    logic geom_match;
    logic can_append;
    logic have_kept;
    logic scan_done;
    logic nearer;
    logic is_last;
    logic emit_done;
  } stat_t;
endpackage
`default_nettype wire

@@ rtl/core/k_nearest_candidate_selector_unit.sv @@
// top level of the k-nearest candidate selector
// instantiates kncs_ctrl and kncs_datapath; depends on kncs_pkg
//
// usage: drive in_* with start high while busy is low; the request is taken
// at that edge. in_func selects start of query or candidate point.
// a start request loads the query and K.
// a candidate is appended when the kept set has room; when the kept set
// is full, the kept-set memory (one read port) is scanned for the farthest
// entry, which the candidate replaces if it is nearer.
// a candidate marked last adds a max scan and then emits the n kept
// results in keep order, each shown for one cycle with out_valid;
// an empty set gives one result with set_empty.
// busy falls in the cycle the last result is shown; a new request may be
// taken at the end of that cycle.
// the receiver cannot stall: results must be taken when out_valid is high.
// reset clears the query, K and the kept count; memory needs no clearing.
`default_nettype none
module k_nearest_candidate_selector_unit #(
  parameter int MAX_K      = kncs_pkg::MAX_K_DEF,
  parameter int COORD_BITS = kncs_pkg::COORD_BITS_DEF,
  parameter int ID_BITS    = kncs_pkg::ID_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_func,
  input  wire logic signed [23:0] in_x_coord,
  input  wire logic signed [23:0] in_y_coord,
  input  wire logic signed [23:0] in_z_coord,
  input  wire logic [15:0] in_geom_id,
  input  wire logic [19:0] in_point_id,
  input  wire logic [5:0]  in_keep_count,
  input  wire logic        in_last_candidate,
  output logic             out_valid,
  output logic [19:0]      out_kept_id,
  output logic [49:0]      out_kept_dist_sq,
  output logic [49:0]      out_max_dist_sq,
  output logic             out_set_empty,
  output logic             out_last_result
);
  import kncs_pkg::*;
  ctrl_t ctl;
  stat_t st;

  kncs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .st(st), .ctl(ctl)
  );

  kncs_datapath #(.MAX_K(MAX_K), .COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_func(in_func), .in_x_coord(in_x_coord),
    .in_y_coord(in_y_coord), .in_z_coord(in_z_coord), .in_geom_id(in_geom_id),
    .in_point_id(in_point_id), .in_keep_count(in_keep_count),
    .in_last_candidate(in_last_candidate), .ctl(ctl), .st(st),
    .out_valid(out_valid), .out_kept_id(out_kept_id),
    .out_kept_dist_sq(out_kept_dist_sq), .out_max_dist_sq(out_max_dist_sq),
    .out_set_empty(out_set_empty), .out_last_result(out_last_result)
  );
endmodule
`default_nettype wire

@@ rtl/core/kncs_ctrl.sv @@
// controller state machine of the k-nearest candidate selector
// depends on kncs_pkg
`default_nettype none
module kncs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire kncs_pkg::stat_t st,
  output kncs_pkg::ctrl_t     ctl
);
  import kncs_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.load_cand = 1'b1;
          state_nxt = ST_DIST;
        end
      end
      ST_DIST: begin
        if (st.is_start) begin
          ctl.load_query = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ctl.calc_dist = 1'b1;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        ctl.calc_sum = 1'b1;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (st.geom_match && st.can_append) begin
          ctl.append = 1'b1;
          state_nxt = st.is_last ? ST_MSCAN : ST_IDLE;
          ctl.scan_init = st.is_last;
        end else if (st.geom_match && st.have_kept) begin
          ctl.scan_init = 1'b1;
          state_nxt = ST_SCAN;
        end else if (st.is_last) begin
          ctl.scan_init = 1'b1;
          state_nxt = ST_MSCAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (st.scan_done) begin
          state_nxt = ST_REPL;
        end else begin
          ctl.scan_read = 1'b1;
          state_nxt = ST_SCANW;
        end
      end
      ST_SCANW: begin
        ctl.scan_step = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_REPL: begin
        if (st.nearer) ctl.replace = 1'b1;
        if (st.is_last) begin
          ctl.scan_init = 1'b1;
          state_nxt = ST_MSCAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MSCAN: begin
        if (!st.have_kept) begin
          state_nxt = ST_EMPTY;
        end else if (st.scan_done) begin
          ctl.emit_init = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          ctl.scan_read = 1'b1;
          state_nxt = ST_MSCANW;
        end
      end
      ST_MSCANW: begin
        ctl.scan_step = 1'b1;
        state_nxt = ST_MSCAN;
      end
      ST_EMIT: begin
        ctl.emit_read = 1'b1;
        state_nxt = ST_EMITW;
      end
      ST_EMITW: begin
        ctl.emit_out = 1'b1;
        state_nxt = st.emit_done ? ST_IDLE : ST_EMIT;
      end
      ST_EMPTY: begin
        ctl.emit_empty = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/core/kncs_datapath.sv @@
// datapath of the k-nearest candidate selector: query registers, distance
// unit, kept-set memory and farthest-entry scan; depends on kncs_pkg
`default_nettype none
module kncs_datapath #(
  parameter int MAX_K      = kncs_pkg::MAX_K_DEF,
  parameter int COORD_BITS = kncs_pkg::COORD_BITS_DEF,
  parameter int ID_BITS    = kncs_pkg::ID_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_func,
  input  wire logic signed [23:0] in_x_coord,
  input  wire logic signed [23:0] in_y_coord,
  input  wire logic signed [23:0] in_z_coord,
  input  wire logic [15:0] in_geom_id,
  input  wire logic [19:0] in_point_id,
  input  wire logic [5:0]  in_keep_count,
  input  wire logic        in_last_candidate,
  input  wire kncs_pkg::ctrl_t ctl,
  output kncs_pkg::stat_t  st,
  output logic             out_valid,
  output logic [19:0]      out_kept_id,
  output logic [49:0]      out_kept_dist_sq,
  output logic [49:0]      out_max_dist_sq,
  output logic             out_set_empty,
  output logic             out_last_result
);
  import kncs_pkg::*;
  localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CW = $clog2(MAX_K + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int SW = 2 * DW;

  logic signed [COORD_BITS-1:0] qx_r, qy_r, qz_r, cx_r, cy_r, cz_r;
  logic [15:0]        qgeom_r, cgeom_r;
  logic [CW-1:0]      limit_r, total_r;
  logic [ID_BITS-1:0] cid_r;
  logic [KEEP_BITS-1:0] kcnt_r;
  logic               func_r, last_r;
  logic [SW-1:0]      sqx_r, sqy_r, sqz_r;
  logic [DIST_BITS-1:0] d_r;

  logic [ID_BITS-1:0]   ids_mem [MAX_K];
  logic [DIST_BITS-1:0] dist_mem [MAX_K];
  logic [ID_BITS-1:0]   rd_id_r;
  logic [DIST_BITS-1:0] rd_dist_r;

  logic [CW-1:0]        idx_r;
  logic [IW-1:0]        best_r;
  logic [DIST_BITS-1:0] best_d_r;
  logic [CW-1:0]        k_sat;

  logic signed [DW-1:0] dx, dy, dz;
  logic [DW-1:0]        ax, ay, az;
  logic [DIST_BITS+1:0] sum;

  assign k_sat = ({1'b0, kcnt_r} > (KEEP_BITS+1)'(MAX_K)) ? CW'(MAX_K) : CW'(kcnt_r);
  assign dx = DW'(cx_r) - DW'(qx_r);
  assign dy = DW'(cy_r) - DW'(qy_r);
  assign dz = DW'(cz_r) - DW'(qz_r);
  assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign az = dz[DW-1] ? DW'(-dz) : DW'(dz);
  assign sum = (DIST_BITS+2)'(sqx_r) + (DIST_BITS+2)'(sqy_r) + (DIST_BITS+2)'(sqz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r <= '0; qy_r <= '0; qz_r <= '0; qgeom_r <= '0;
      limit_r <= '0; total_r <= '0; out_valid <= 1'b0;
    end else begin
      out_valid <= ctl.emit_out | ctl.emit_empty;
      if (ctl.load_query) begin
        qx_r <= cx_r; qy_r <= cy_r; qz_r <= cz_r; qgeom_r <= cgeom_r;
        limit_r <= k_sat; total_r <= '0;
      end
      if (ctl.append) total_r <= total_r + 1'b1;
      if (ctl.emit_empty || (ctl.emit_out && st.emit_done)) total_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_cand) begin
      func_r <= in_func; last_r <= in_last_candidate;
      cx_r <= in_x_coord[COORD_BITS-1:0];
      cy_r <= in_y_coord[COORD_BITS-1:0];
      cz_r <= in_z_coord[COORD_BITS-1:0];
      cgeom_r <= in_geom_id;
      cid_r <= ID_BITS'(in_point_id);
      kcnt_r <= in_keep_count;
    end
    if (ctl.calc_dist) begin
      sqx_r <= ax * ax; sqy_r <= ay * ay; sqz_r <= az * az;
    end
    if (ctl.calc_sum) d_r <= sum[DIST_BITS-1:0];
    if (ctl.append) begin
      ids_mem[total_r[IW-1:0]]  <= cid_r;
      dist_mem[total_r[IW-1:0]] <= d_r;
    end
    if (ctl.replace) begin
      ids_mem[best_r]  <= cid_r;
      dist_mem[best_r] <= d_r;
    end
    if (ctl.scan_read || ctl.emit_read) begin
      rd_id_r   <= ids_mem[idx_r[IW-1:0]];
      rd_dist_r <= dist_mem[idx_r[IW-1:0]];
    end
    if (ctl.scan_init || ctl.emit_init) idx_r <= '0;
    if (ctl.scan_init) begin
      best_r <= '0; best_d_r <= '0;
    end
    if (ctl.scan_step) begin
      if (idx_r == '0 || rd_dist_r > best_d_r) begin
        best_r <= idx_r[IW-1:0]; best_d_r <= rd_dist_r;
      end
      idx_r <= idx_r + 1'b1;
    end
    if (ctl.emit_out) idx_r <= idx_r + 1'b1;
    if (ctl.emit_out) begin
      out_kept_id <= OUT_ID_BITS'(rd_id_r);
      out_kept_dist_sq <= rd_dist_r;
      out_max_dist_sq <= best_d_r;
      out_set_empty <= 1'b0;
      out_last_result <= st.emit_done;
    end
    if (ctl.emit_empty) begin
      out_kept_id <= '0; out_kept_dist_sq <= '0; out_max_dist_sq <= '0;
      out_set_empty <= 1'b1; out_last_result <= 1'b1;
    end
  end

  always_comb begin
    st.is_start   = (func_r == FUNC_START);
    st.geom_match = (cgeom_r == qgeom_r);
    st.can_append = (total_r < limit_r);
    st.have_kept  = (total_r != '0);
    st.scan_done  = (idx_r >= total_r);
    st.nearer     = (d_r < best_d_r);
    st.is_last    = last_r;
    st.emit_done  = ((idx_r + 1'b1) == total_r);
  end
endmodule
`default_nettype wire

@@ rtl/core/kncs_checker.sv @@
// port-level checker for the k-nearest candidate selector
// bound to k_nearest_candidate_selector_unit
`default_nettype none
module kncs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [19:0] out_kept_id,
  input wire logic [49:0] out_kept_dist_sq,
  input wire logic [49:0] out_max_dist_sq,
  input wire logic        out_set_empty,
  input wire logic        out_last_result
);
  a_dist_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kept_dist_sq <= out_max_dist_sq) else $error("dist above max");
  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_set_empty) |-> (out_last_result && out_kept_id == 0 &&
    out_max_dist_sq == 0)) else $error("empty result not clean");
  a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("results back to back");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request not taken");
endmodule

bind k_nearest_candidate_selector_unit kncs_checker u_kncs_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_kept_id(out_kept_id), .out_kept_dist_sq(out_kept_dist_sq),
  .out_max_dist_sq(out_max_dist_sq), .out_set_empty(out_set_empty),
  .out_last_result(out_last_result)
);
`default_nettype wire

@@ sim/tb.sv @@
// testbench for k_nearest_candidate_selector_unit: random and directed query/candidate requests
// a scoreboard class predicts the kept set and checks every emitted result; depends on kncs_pkg
`timescale 1ns / 100ps
module tb;
  import kncs_pkg::*;

  localparam int KMAX = MAX_K_DEF;
  localparam longint LIMIT = 2000000;

  typedef struct packed {
    logic [19:0] id;
    logic [49:0] dsq;
    logic [49:0] maxd;
    logic        empty;
    logic        last;
  } kept_res_t;

  class knn_scoreboard;
    logic signed [23:0] qx, qy, qz;
    logic [15:0] qgeom;
    int unsigned klim;
    int unsigned total;
    logic [19:0] ids [KMAX];
    logic [49:0] dists [KMAX];
    kept_res_t pending [$];
    int errors;
    int checked;

    function new();
      qx = 0; qy = 0; qz = 0; qgeom = 0; klim = 0; total = 0;
      errors = 0; checked = 0;
    endfunction

    function logic [49:0] sqdist(logic signed [23:0] x, logic signed [23:0] y,
                                 logic signed [23:0] z);
      logic signed [51:0] dx, dy, dz;
      logic [51:0] s;
      dx = 52'(x) - 52'(qx);
      dy = 52'(y) - 52'(qy);
      dz = 52'(z) - 52'(qz);
      s = dx * dx + dy * dy + dz * dz;
      return s[49:0];
    endfunction

    function int unsigned farthest();
      int unsigned b;
      b = 0;
      for (int unsigned i = 1; i < total; i++)
        if (dists[i] > dists[b]) b = i;
      return b;
    endfunction

    function void note_request(logic func, logic signed [23:0] x, logic signed [23:0] y,
                               logic signed [23:0] z, logic [15:0] g, logic [19:0] pid,
                               logic [5:0] k, logic lastc);
      logic [49:0] d;
      int unsigned f;
      kept_res_t r;
      if (func == FUNC_START) begin
        qx = x; qy = y; qz = z; qgeom = g;
        klim = (k > KMAX) ? KMAX : k;
        total = 0;
        return;
      end
      if (g == qgeom) begin
        d = sqdist(x, y, z);
        if (total < klim) begin
          ids[total] = pid; dists[total] = d; total++;
        end else if (total > 0) begin
          f = farthest();
          if (d < dists[f]) begin
            ids[f] = pid; dists[f] = d;
          end
        end
      end
      if (!lastc) return;
      if (total == 0) begin
        r = '0; r.empty = 1; r.last = 1;
        pending = {pending, r};
      end else begin
        f = farthest();
        for (int unsigned i = 0; i < total; i++) begin
          r.id = ids[i]; r.dsq = dists[i]; r.maxd = dists[f];
          r.empty = 0; r.last = (i + 1 == total);
          pending = {pending, r};
        end
      end
      total = 0;
    endfunction

    function void check_result(kept_res_t a);
      kept_res_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result id=%h dsq=%h", a.id, a.dsq);
        return;
      end
      e = pending.pop_front();
      if (a !== e) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp id=%h dsq=%h max=%h empty=%b last=%b",
                    " / got id=%h dsq=%h max=%h empty=%b last=%b"},
                   e.id, e.dsq, e.maxd, e.empty, e.last,
                   a.id, a.dsq, a.maxd, a.empty, a.last);
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy;
  logic in_func;
  logic signed [23:0] in_x_coord, in_y_coord, in_z_coord;
  logic [15:0] in_geom_id;
  logic [19:0] in_point_id;
  logic [5:0]  in_keep_count;
  logic        in_last_candidate;
  logic        out_valid;
  logic [19:0] out_kept_id;
  logic [49:0] out_kept_dist_sq, out_max_dist_sq;
  logic        out_set_empty, out_last_result;

  knn_scoreboard sb;
  longint cycles;
  int requests;
  int quiet;
  logic signed [23:0] cx, cy, cz;
  logic [15:0] cur_geom;

  k_nearest_candidate_selector_unit DUT (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid)
      sb.check_result({out_kept_id, out_kept_dist_sq, out_max_dist_sq,
                       out_set_empty, out_last_result});
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_request(logic func, logic signed [23:0] x, logic signed [23:0] y,
                              logic signed [23:0] z, logic [15:0] g, logic [19:0] pid,
                              logic [5:0] k, logic lastc);
    if (quiet == 0 && $urandom_range(99) < 18) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start <= 1; in_func <= func;
    in_x_coord <= x; in_y_coord <= y; in_z_coord <= z;
    in_geom_id <= g; in_point_id <= pid; in_keep_count <= k; in_last_candidate <= lastc;
    while (busy) @(negedge clk);
    @(posedge clk);
    sb.note_request(func, x, y, z, g, pid, k, lastc);
    requests++;
    @(negedge clk);
  endtask

  function automatic logic signed [23:0] rnd_coord();
    case ($urandom_range(5))
      0: return 24'sh800000;
      1: return 24'sh7fffff;
      2: return cx + $signed(24'($urandom_range(64))) - 24'sd32;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic run_query(int n, logic [5:0] k);
    logic [15:0] g;
    cur_geom = 16'($urandom);
    cx = 24'($urandom); cy = 24'($urandom); cz = 24'($urandom);
    send_request(FUNC_START, cx, cy, cz, cur_geom, 20'($urandom), k, $urandom_range(1));
    for (int i = 0; i < n; i++) begin
      g = ($urandom_range(9) == 0) ? 16'($urandom) : cur_geom;
      send_request(FUNC_CAND, rnd_coord(), rnd_coord(), rnd_coord(), g, 20'($urandom),
                   6'($urandom), i == n - 1);
    end
  endtask

  initial begin
    sb = new();
    cycles = 0; requests = 0; quiet = 0;
    rst_n = 0; start = 0; in_func = 0;
    in_x_coord = 0; in_y_coord = 0; in_z_coord = 0; in_geom_id = 0;
    in_point_id = 0; in_keep_count = 0; in_last_candidate = 0;
    cx = 0; cy = 0; cz = 0; cur_geom = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // candidate before any start, reset query has K zero
    send_request(FUNC_CAND, 0, 0, 0, 0, 20'hfffff, 6'h3f, 1);
    // extremes, K zero, ties on the farthest
    send_request(FUNC_START, 24'sh800000, 24'sh800000, 24'sh800000, 16'hffff, 0, 0, 1);
    send_request(FUNC_CAND, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 16'hffff, 1, 0, 1);
    send_request(FUNC_START, 24'sh800000, 24'sh800000, 24'sh800000, 16'hffff, 0, 2, 0);
    send_request(FUNC_CAND, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 16'hffff, 20'hfffff, 0, 0);
    send_request(FUNC_CAND, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 16'hffff, 20'h12345, 0, 0);
    send_request(FUNC_CAND, 24'sh000000, 24'sh7fffff, 24'sh7fffff, 16'hffff, 20'h00001, 0, 0);
    send_request(FUNC_CAND, 24'sh000000, 24'sh000000, 24'sh000000, 16'hfffe, 20'h00002, 0, 1);
    // same query after emission, equal distance must not replace
    send_request(FUNC_CAND, 24'sh000000, 24'sh000000, 24'sh000000, 16'hffff, 20'h3, 0, 0);
    send_request(FUNC_CAND, 24'sh000000, 24'sh000000, 24'sh000000, 16'hffff, 20'h4, 0, 0);
    send_request(FUNC_CAND, 24'sh000000, 24'sh000000, 24'sh000000, 16'hffff, 20'h5, 0, 1);
    // K above max saturates
    run_query(3, 6'h3f);
    run_query(34, 6'd33);

    while (requests < 300) begin
      quiet = (requests > 150 && requests < 200);
      case ($urandom_range(9))
        0: run_query($urandom_range(1, 40), 6'($urandom_range(33, 63)));
        1: run_query($urandom_range(1, 6), 6'd0);
        default: run_query($urandom_range(1, 14), 6'($urandom_range(1, 8)));
      endcase
    end

    start <= 0;
    @(negedge clk);
    while (busy || sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("%0d requests sent, %0d results checked, %0d errors",
             requests, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
